/* rtl/limit_order_matching_book_defines.svh */
// Assertion macros used by the checker file of the order matching book.
`ifndef LIMIT_ORDER_MATCHING_BOOK_DEFINES_SVH
`define LIMIT_ORDER_MATCHING_BOOK_DEFINES_SVH

// Clocked property with an active-low reset that disables the check.
`define LOMB_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Same-cycle implication.
`define LOMB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    `LOMB_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LOMB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    `LOMB_ASSERT(lbl, ck, rn, (ante) |=> (cons), msg)

`endif

/* rtl/lomb_pkg.sv */
// Types and codes shared by the order matching book modules.
package lomb_pkg;

    typedef enum logic [1:0] {
        OP_NEW,
        OP_MODIFY,
        OP_CANCEL,
        OP_REPORT
    } op_e;

    typedef enum logic [2:0] {
        ST_RESTED,
        ST_TRADED,
        ST_DUPLICATE,
        ST_NOT_FOUND,
        ST_CANCELLED,
        ST_REPRICED,
        ST_BOOK_FULL,
        ST_REPORT
    } status_e;

    typedef enum logic [3:0] {
        E_CLEAR,
        E_IDLE,
        E_SCAN,
        E_DRAIN,
        E_DECIDE,
        E_RDF,
        E_RDC,
        E_WRF,
        E_WRC,
        E_OUT
    } eng_state_e;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  firm;
        logic [15:0] symbol;
        logic        side;
        logic [23:0] price;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         counter_firm;
        logic [23:0]        trade_price;
        logic [8:0]         firm_open;
        logic [31:0]        firm_trades;
        logic signed [47:0] firm_cash;
        logic [8:0]         counter_open;
        logic [31:0]        counter_trades;
        logic signed [47:0] counter_cash;
    } rsp_t;

    // Classified command passed from the front end to the engine.
    typedef struct packed {
        op_e         op;
        logic [7:0]  firm;
        logic [15:0] symbol;
        logic        side;
        logic [23:0] price;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  firm;
        logic [15:0] symbol;
        logic        side;
        logic [23:0] price;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [8:0]         open;
        logic [31:0]        trades;
        logic signed [47:0] cash;
    } stat_t;

endpackage

/* rtl/lomb_front.sv */
// Front end: accepts request transactions and reduces the firm index.
module lomb_front #(
    parameter int unsigned FIRM_COUNT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lomb_pkg::req_t req,
    output logic          push,
    output lomb_pkg::cmd_t push_data,
    input  logic          q_full
);
    import lomb_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    cmd_t       front_reg;
    logic [7:0] fmod_tab [256];
    logic       accept;

    // Firm index modulo the firm count, as a constant table.
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign fmod_tab[g] = 8'(g % FIRM_COUNT);
    end

    assign req_stall = front_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_data = front_reg;

    always_comb
    begin
        front_valid_next = accept || (front_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg.op     <= op_e'(req.op);
            front_reg.firm   <= fmod_tab[req.firm];
            front_reg.symbol <= req.symbol;
            front_reg.side   <= req.side;
            front_reg.price  <= req.price;
        end
    end

endmodule

/* rtl/lomb_queue.sv */
// Two-entry command queue between the front end and the engine.
module lomb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lomb_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output lomb_pkg::cmd_t pop_data,
    output logic           empty
);
    import lomb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/lomb_engine.sv */
// Back end: scans the book, decides the outcome and updates book and counters.
module lomb_engine #(
    parameter int unsigned BOOK_DEPTH = 256,
    parameter int unsigned FIRM_COUNT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lomb_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lomb_pkg::rsp_t rsp
);
    import lomb_pkg::*;

    localparam int unsigned AW    = $clog2(BOOK_DEPTH);
    localparam int unsigned FAW   = $clog2(FIRM_COUNT);
    localparam int unsigned CLR_N = (BOOK_DEPTH > FIRM_COUNT) ? BOOK_DEPTH : FIRM_COUNT;
    localparam int unsigned CLRW  = $clog2(CLR_N);

    function automatic logic signed [47:0] cash_sat(input logic signed [47:0] a,
                                                    input logic [24:0] d);
        logic [48:0] s;
        s = {a[47], a} + {{24{d[24]}}, d};
        if (s[48] != s[47])
        begin
            cash_sat = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            cash_sat = s[47:0];
        end
    endfunction

    function automatic logic [8:0] open_dec(input logic [8:0] x);
        open_dec = (x == 9'd0) ? 9'd0 : x - 9'd1;
    endfunction

    function automatic logic [8:0] open_inc(input logic [8:0] x);
        open_inc = (x == 9'h1FF) ? x : x + 9'd1;
    endfunction

    function automatic logic [31:0] trades_inc(input logic [31:0] x);
        trades_inc = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    // Memories.
    entry_t          entry_mem [BOOK_DEPTH];
    stat_t           stat_mem  [FIRM_COUNT];
    logic            ent_we;
    logic [AW-1:0]   ent_waddr;
    entry_t          ent_wdata;
    logic [AW-1:0]   ent_raddr;
    entry_t          ent_rdata;
    logic            st_we;
    logic [FAW-1:0]  st_waddr;
    stat_t           st_wdata;
    logic [FAW-1:0]  st_raddr;
    stat_t           st_rdata;

    // Control.
    eng_state_e      state_reg;
    eng_state_e      state_next;
    logic [CLRW-1:0] clr_cnt_reg;
    logic [AW-1:0]   scan_cnt_reg;
    logic            chk_reg;
    logic [AW-1:0]   chk_idx_reg;
    logic [31:0]     next_stamp_reg;
    logic            own_found_reg;
    logic            free_found_reg;
    logic            bid_found_reg;
    logic            ask_found_reg;
    logic            rsp_valid_reg;

    // Datapath.
    cmd_t            cmd_reg;
    logic [AW-1:0]   own_idx_reg;
    entry_t          own_ent_reg;
    logic [AW-1:0]   free_idx_reg;
    logic [AW-1:0]   bid_idx_reg;
    logic [23:0]     bid_price_reg;
    logic [31:0]     bid_age_reg;
    logic [7:0]      bid_firm_reg;
    logic [AW-1:0]   ask_idx_reg;
    logic [23:0]     ask_price_reg;
    logic [31:0]     ask_age_reg;
    logic [7:0]      ask_firm_reg;
    status_e         status_reg;
    logic            side_reg;
    logic [AW-1:0]   m_idx_reg;
    logic [23:0]     tp_reg;
    logic [7:0]      cf_reg;
    stat_t           fstat_reg;
    stat_t           cstat_reg;
    stat_t           fnew_reg;
    stat_t           cnew_reg;
    rsp_t            rsp_reg;

    // Scan evaluation.
    entry_t          e;
    logic [31:0]     e_age;
    logic            hit_own;
    logic            cand;
    logic            bid_take;
    logic            ask_take;

    // Decision.
    logic            eff_side;
    logic            m_found;
    logic [AW-1:0]   m_idx;
    logic [23:0]     m_price;
    logic [7:0]      m_firm;
    status_e         dec_status;
    logic [24:0]     d_f;
    logic [24:0]     d_c;
    logic            is_trade;
    logic            is_mod_trade;
    stat_t           f_new;
    stat_t           c_new;
    logic            rsp_load;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= entry_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stat_mem[st_waddr] <= st_wdata;
        end
        st_rdata <= stat_mem[st_raddr];
    end

    always_comb
    begin
        e        = ent_rdata;
        e_age    = next_stamp_reg - e.stamp;
        hit_own  = e.valid && (e.firm == cmd_reg.firm) && (e.symbol == cmd_reg.symbol);
        cand     = e.valid && (e.symbol == cmd_reg.symbol) && (e.firm != cmd_reg.firm);
        bid_take = cand && !e.side && (e.price >= cmd_reg.price) &&
                   (!bid_found_reg || ((e.price == bid_price_reg) ? (e_age > bid_age_reg)
                                                                  : (e.price > bid_price_reg)));
        ask_take = cand && e.side && (e.price <= cmd_reg.price) &&
                   (!ask_found_reg || ((e.price == ask_price_reg) ? (e_age > ask_age_reg)
                                                                  : (e.price < ask_price_reg)));
    end

    always_comb
    begin
        eff_side = (cmd_reg.op == OP_NEW) ? cmd_reg.side : own_ent_reg.side;
        m_found  = eff_side ? bid_found_reg : ask_found_reg;
        m_idx    = eff_side ? bid_idx_reg   : ask_idx_reg;
        m_price  = eff_side ? bid_price_reg : ask_price_reg;
        m_firm   = eff_side ? bid_firm_reg  : ask_firm_reg;
        case (cmd_reg.op)
            OP_NEW:
            begin
                if (own_found_reg)
                    dec_status = ST_DUPLICATE;
                else if (m_found)
                    dec_status = ST_TRADED;
                else if (free_found_reg)
                    dec_status = ST_RESTED;
                else
                    dec_status = ST_BOOK_FULL;
            end
            OP_MODIFY:
            begin
                if (!own_found_reg)
                    dec_status = ST_NOT_FOUND;
                else if (m_found)
                    dec_status = ST_TRADED;
                else
                    dec_status = ST_REPRICED;
            end
            OP_CANCEL:
            begin
                dec_status = own_found_reg ? ST_CANCELLED : ST_NOT_FOUND;
            end
            default:
            begin
                dec_status = ST_REPORT;
            end
        endcase
    end

    // Counter updates for the acting firm and the counterparty.
    always_comb
    begin
        is_trade     = (status_reg == ST_TRADED);
        is_mod_trade = is_trade && (cmd_reg.op == OP_MODIFY);
        d_f          = side_reg ? {1'b0, tp_reg} : (25'd0 - {1'b0, tp_reg});
        d_c          = 25'd0 - d_f;
        f_new        = fstat_reg;
        if (is_mod_trade || (status_reg == ST_CANCELLED))
        begin
            f_new.open = open_dec(fstat_reg.open);
        end
        else if (status_reg == ST_RESTED)
        begin
            f_new.open = open_inc(fstat_reg.open);
        end
        if (is_trade)
        begin
            f_new.trades = trades_inc(fstat_reg.trades);
            f_new.cash   = cash_sat(fstat_reg.cash, d_f);
        end
        c_new.open   = open_dec(cstat_reg.open);
        c_new.trades = trades_inc(cstat_reg.trades);
        c_new.cash   = cash_sat(cstat_reg.cash, d_c);
    end

    assign rsp_load = (state_reg == E_OUT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_CLEAR:
            begin
                if (clr_cnt_reg == CLRW'(CLR_N - 1))
                    state_next = E_IDLE;
            end
            E_IDLE:
            begin
                if (!q_empty)
                    state_next = E_SCAN;
            end
            E_SCAN:
            begin
                if (scan_cnt_reg == AW'(BOOK_DEPTH - 1))
                    state_next = E_DRAIN;
            end
            E_DRAIN:  state_next = E_DECIDE;
            E_DECIDE: state_next = E_RDF;
            E_RDF:    state_next = E_RDC;
            E_RDC:    state_next = E_WRF;
            E_WRF:    state_next = E_WRC;
            E_WRC:    state_next = E_OUT;
            E_OUT:
            begin
                if (rsp_load)
                    state_next = E_IDLE;
            end
            default:  state_next = E_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = own_idx_reg;
        ent_wdata = '0;
        ent_raddr = scan_cnt_reg;
        st_we     = 1'b0;
        st_waddr  = FAW'(cmd_reg.firm);
        st_wdata  = f_new;
        st_raddr  = FAW'(cmd_reg.firm);
        case (state_reg)
            E_CLEAR:
            begin
                ent_we    = (32'(clr_cnt_reg) < BOOK_DEPTH);
                ent_waddr = AW'(clr_cnt_reg);
                st_we     = (32'(clr_cnt_reg) < FIRM_COUNT);
                st_waddr  = FAW'(clr_cnt_reg);
                st_wdata  = '0;
            end
            E_IDLE:
            begin
                q_pop = !q_empty;
            end
            E_RDC:
            begin
                st_raddr = FAW'(cf_reg);
            end
            E_WRF:
            begin
                st_raddr = FAW'(cf_reg);
                st_we    = 1'b1;
                case (status_reg)
                    ST_RESTED:
                    begin
                        ent_we           = 1'b1;
                        ent_waddr        = free_idx_reg;
                        ent_wdata.valid  = 1'b1;
                        ent_wdata.firm   = cmd_reg.firm;
                        ent_wdata.symbol = cmd_reg.symbol;
                        ent_wdata.side   = cmd_reg.side;
                        ent_wdata.price  = cmd_reg.price;
                        ent_wdata.stamp  = next_stamp_reg;
                    end
                    ST_TRADED:
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = m_idx_reg;
                    end
                    ST_CANCELLED:
                    begin
                        ent_we = 1'b1;
                    end
                    ST_REPRICED:
                    begin
                        ent_we          = 1'b1;
                        ent_wdata       = own_ent_reg;
                        ent_wdata.price = cmd_reg.price;
                    end
                    default:
                    begin
                        ent_we = 1'b0;
                    end
                endcase
            end
            E_WRC:
            begin
                ent_we   = is_mod_trade;
                st_we    = is_trade;
                st_waddr = FAW'(cf_reg);
                st_wdata = c_new;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_CLEAR;
            clr_cnt_reg    <= '0;
            scan_cnt_reg   <= '0;
            chk_reg        <= 1'b0;
            next_stamp_reg <= 32'd0;
            own_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            bid_found_reg  <= 1'b0;
            ask_found_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= (state_reg == E_SCAN);
            if (state_reg == E_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLRW'(1);
            end
            if (state_reg == E_IDLE)
            begin
                scan_cnt_reg   <= '0;
                own_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                bid_found_reg  <= 1'b0;
                ask_found_reg  <= 1'b0;
            end
            else if (state_reg == E_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + AW'(1);
            end
            if (chk_reg)
            begin
                if (hit_own && !own_found_reg)
                    own_found_reg <= 1'b1;
                if (!e.valid && !free_found_reg)
                    free_found_reg <= 1'b1;
                if (bid_take)
                    bid_found_reg <= 1'b1;
                if (ask_take)
                    ask_found_reg <= 1'b1;
            end
            if ((state_reg == E_WRF) && (status_reg == ST_RESTED))
            begin
                next_stamp_reg <= next_stamp_reg + 32'd1;
            end
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= scan_cnt_reg;
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (chk_reg)
        begin
            if (hit_own && !own_found_reg)
            begin
                own_idx_reg <= chk_idx_reg;
                own_ent_reg <= e;
            end
            if (!e.valid && !free_found_reg)
                free_idx_reg <= chk_idx_reg;
            if (bid_take)
            begin
                bid_idx_reg   <= chk_idx_reg;
                bid_price_reg <= e.price;
                bid_age_reg   <= e_age;
                bid_firm_reg  <= e.firm;
            end
            if (ask_take)
            begin
                ask_idx_reg   <= chk_idx_reg;
                ask_price_reg <= e.price;
                ask_age_reg   <= e_age;
                ask_firm_reg  <= e.firm;
            end
        end
        if (state_reg == E_DECIDE)
        begin
            status_reg <= dec_status;
            side_reg   <= eff_side;
            m_idx_reg  <= m_idx;
            tp_reg     <= eff_side ? cmd_reg.price : m_price;
            cf_reg     <= m_firm;
        end
        if (state_reg == E_RDC)
            fstat_reg <= st_rdata;
        if (state_reg == E_WRF)
        begin
            cstat_reg <= st_rdata;
            fnew_reg  <= f_new;
        end
        if (state_reg == E_WRC)
            cnew_reg <= c_new;
        if (rsp_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.firm_open   <= fnew_reg.open;
            rsp_reg.firm_trades <= fnew_reg.trades;
            rsp_reg.firm_cash   <= fnew_reg.cash;
            if (is_trade)
            begin
                rsp_reg.counter_firm   <= cf_reg;
                rsp_reg.trade_price    <= tp_reg;
                rsp_reg.counter_open   <= cnew_reg.open;
                rsp_reg.counter_trades <= cnew_reg.trades;
                rsp_reg.counter_cash   <= cnew_reg.cash;
            end
            else
            begin
                rsp_reg.counter_firm   <= 8'd0;
                rsp_reg.trade_price    <= 24'd0;
                rsp_reg.counter_open   <= 9'd0;
                rsp_reg.counter_trades <= 32'd0;
                rsp_reg.counter_cash   <= 48'sd0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/limit_order_matching_book.sv */
// Top level of the limit order matching book.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   request  | req_valid/req_stall | req: op, firm, symbol, side, price
//   response | rsp_valid/rsp_stall | rsp: status, counters, trade details
//
// The engine walks the whole book through one read port of the entry memory,
// one entry per cycle, then reads and writes the firm counter memory.
// After reset a clearing pass zeroes both memories; requests are queued but
// not processed until it ends.
// The front end and a two-entry queue keep taking requests while the engine
// works, until the queue fills, and a response that is stalled waits in the
// output register.
module limit_order_matching_book #(
    parameter int unsigned BOOK_DEPTH = 256,
    parameter int unsigned FIRM_COUNT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lomb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lomb_pkg::rsp_t rsp
);
    import lomb_pkg::*;

    // Front end to queue.
    logic push;
    cmd_t push_data;
    logic q_full;

    // Queue to engine.
    logic q_pop;
    cmd_t q_data;
    logic q_empty;

    // The front end reduces the firm index and holds one request.
    lomb_front #(
        .FIRM_COUNT(FIRM_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // The queue decouples request intake from the slow book scan.
    lomb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // The engine owns the book and counter memories and forms responses.
    lomb_engine #(
        .BOOK_DEPTH(BOOK_DEPTH),
        .FIRM_COUNT(FIRM_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* rtl/lomb_checker.sv */
// Port-level assertions for the order matching book and their bind.
`include "limit_order_matching_book_defines.svh"

module lomb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lomb_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lomb_pkg::rsp_t rsp
);
    import lomb_pkg::*;

    `LOMB_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
    `LOMB_ASSERT_IMP(a_no_trade_zero, clk, rst_n, rsp_valid && (rsp.status != ST_TRADED), (rsp.counter_firm == 8'd0) && (rsp.trade_price == 24'd0) && (rsp.counter_trades == 32'd0), "counter fields set without a trade")
    `LOMB_ASSERT_IMP(a_trade_counts, clk, rst_n, rsp_valid && (rsp.status == ST_TRADED), (rsp.firm_trades != 32'd0) && (rsp.counter_trades != 32'd0), "trade without trade counts")
    `LOMB_ASSERT_IMP(a_rest_open, clk, rst_n, rsp_valid && (rsp.status == ST_RESTED), rsp.firm_open != 9'd0, "rested order without open count")

endmodule

bind limit_order_matching_book lomb_checker u_lomb_checker (.*);
